[design/eps_pkg.sv]
// ----------------------------------------------------------------------------
// eps_pkg
// Types and constants shared by the edge pair stack test.
// ----------------------------------------------------------------------------
package eps_pkg;

  localparam int COORD_BITS = 12;
  localparam int TOL_BITS   = 16;

  typedef struct packed {
    logic [COORD_BITS-1:0] a_x0;
    logic [COORD_BITS-1:0] a_y0;
    logic [COORD_BITS-1:0] a_x1;
    logic [COORD_BITS-1:0] a_y1;
    logic [COORD_BITS-1:0] b_x0;
    logic [COORD_BITS-1:0] b_y0;
    logic [COORD_BITS-1:0] b_x1;
    logic [COORD_BITS-1:0] b_y1;
  } in_t;

  typedef struct packed {
    logic parallel;
    logic on_top;
    logic stacked;
  } out_t;

endpackage

[design/edge_pair_stack_test.sv]
// An accepted input item passes the five pipeline stages to its result item.
// Throughput: one item per cycle while out_ready is high; a stage stalls
// only where it holds an item that the next stage cannot take.
// Reset: rst clears all stage valid bits and sets parallel_tolerance to 0.
// ----------------------------------------------------------------------------
// edge_pair_stack_test
// Tests an edge pair for parallelism (cross determinant within tolerance) and
// for stacking (vertical probe from the lower midpoint meets the other edge).
// ----------------------------------------------------------------------------
module edge_pair_stack_test (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [eps_pkg::TOL_BITS-1:0]       cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  eps_pkg::in_t                       in_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output eps_pkg::out_t                      out_item
);

  localparam int CB = eps_pkg::COORD_BITS;
  localparam int DW = CB + 1;
  localparam int PW = 2 * DW;
  localparam int VW = PW + 1;

  typedef enum logic [1:0] {
    TURN_COL = 2'd0,
    TURN_CW  = 2'd1,
    TURN_CCW = 2'd2
  } turn_t;

  function automatic logic signed [DW-1:0] sdiff(input logic [CB-1:0] a,
                                                 input logic [CB-1:0] b);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  function automatic turn_t sign_turn(input logic signed [DW-1:0] a,
                                      input logic signed [DW-1:0] b);
    turn_t t;
    if (a == '0 || b == '0) begin
      t = TURN_COL;
    end else if (a[DW-1] == b[DW-1]) begin
      t = TURN_CW;
    end else begin
      t = TURN_CCW;
    end
    return t;
  endfunction

  function automatic turn_t val_turn(input logic signed [VW-1:0] v);
    turn_t t;
    if (v == '0) begin
      t = TURN_COL;
    end else if (!v[VW-1]) begin
      t = TURN_CW;
    end else begin
      t = TURN_CCW;
    end
    return t;
  endfunction

  function automatic logic between(input logic [CB-1:0] q,
                                   input logic [CB-1:0] p,
                                   input logic [CB-1:0] r);
    return (q >= p && q <= r) || (q >= r && q <= p);
  endfunction

  logic [eps_pkg::TOL_BITS-1:0] parallel_tolerance;

  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !v5 || out_ready;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // stage 1: midpoints, probe and target selection
  logic [CB:0]   a_ysum, b_ysum, a_xsum, b_xsum;
  logic [CB-1:0] a_mid_y, b_mid_y;
  logic          pick_a;

  assign a_ysum  = {1'b0, in_item.a_y0} + {1'b0, in_item.a_y1};
  assign b_ysum  = {1'b0, in_item.b_y0} + {1'b0, in_item.b_y1};
  assign a_xsum  = {1'b0, in_item.a_x0} + {1'b0, in_item.a_x1};
  assign b_xsum  = {1'b0, in_item.b_x0} + {1'b0, in_item.b_x1};
  assign a_mid_y = a_ysum[CB:1];
  assign b_mid_y = b_ysum[CB:1];
  assign pick_a  = a_mid_y < b_mid_y;

  logic signed [DW-1:0] s1_dax, s1_day, s1_dbx, s1_dby;
  logic [CB-1:0]        s1_sx, s1_sy, s1_ey, s1_t0x, s1_t0y, s1_t1x, s1_t1y;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_dax <= sdiff(in_item.a_x1, in_item.a_x0);
      s1_day <= sdiff(in_item.a_y1, in_item.a_y0);
      s1_dbx <= sdiff(in_item.b_x1, in_item.b_x0);
      s1_dby <= sdiff(in_item.b_y1, in_item.b_y0);
      if (pick_a) begin
        s1_sx  <= a_xsum[CB:1];
        s1_sy  <= a_mid_y;
        s1_ey  <= (in_item.b_y0 > in_item.b_y1) ? in_item.b_y0 : in_item.b_y1;
        s1_t0x <= in_item.b_x0;
        s1_t0y <= in_item.b_y0;
        s1_t1x <= in_item.b_x1;
        s1_t1y <= in_item.b_y1;
      end else begin
        s1_sx  <= b_xsum[CB:1];
        s1_sy  <= b_mid_y;
        s1_ey  <= (in_item.a_y0 > in_item.a_y1) ? in_item.a_y0 : in_item.a_y1;
        s1_t0x <= in_item.a_x0;
        s1_t0y <= in_item.a_y0;
        s1_t1x <= in_item.a_x1;
        s1_t1y <= in_item.a_y1;
      end
    end
  end

  // stage 2: determinant products, probe turns, box tests, target differences
  logic signed [PW-1:0] s2_pad, s2_pbc;
  logic signed [DW-1:0] s2_tdx, s2_tdy, s2_ex, s2_esy, s2_eey;
  turn_t                s2_o1, s2_o2;
  logic [3:0]           s2_box;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_pad    <= PW'(s1_dax) * PW'(s1_dby);
      s2_pbc    <= PW'(s1_day) * PW'(s1_dbx);
      s2_tdx    <= sdiff(s1_t1x, s1_t0x);
      s2_tdy    <= sdiff(s1_t1y, s1_t0y);
      s2_ex     <= sdiff(s1_sx, s1_t1x);
      s2_esy    <= sdiff(s1_sy, s1_t1y);
      s2_eey    <= sdiff(s1_ey, s1_t1y);
      s2_o1     <= sign_turn(sdiff(s1_ey, s1_sy), sdiff(s1_t0x, s1_sx));
      s2_o2     <= sign_turn(sdiff(s1_ey, s1_sy), sdiff(s1_t1x, s1_sx));
      s2_box[0] <= (s1_t0x == s1_sx) && between(s1_t0y, s1_sy, s1_ey);
      s2_box[1] <= (s1_t1x == s1_sx) && between(s1_t1y, s1_sy, s1_ey);
      s2_box[2] <= between(s1_sx, s1_t0x, s1_t1x) && between(s1_sy, s1_t0y, s1_t1y);
      s2_box[3] <= between(s1_sx, s1_t0x, s1_t1x) && between(s1_ey, s1_t0y, s1_t1y);
    end
  end

  // stage 3: target turn products, determinant
  logic signed [PW-1:0] s3_m1, s3_m2, s3_m3;
  logic signed [VW-1:0] s3_det;
  turn_t                s3_o1, s3_o2;
  logic [3:0]           s3_box;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_m1  <= PW'(s2_tdy) * PW'(s2_ex);
      s3_m2  <= PW'(s2_tdx) * PW'(s2_esy);
      s3_m3  <= PW'(s2_tdx) * PW'(s2_eey);
      s3_det <= VW'(s2_pad) - VW'(s2_pbc);
      s3_o1  <= s2_o1;
      s3_o2  <= s2_o2;
      s3_box <= s2_box;
    end
  end

  // stage 4: target turn values, absolute determinant
  logic signed [VW-1:0] s4_v3, s4_v4;
  logic [VW-1:0]        s4_absdet;
  turn_t                s4_o1, s4_o2;
  logic [3:0]           s4_box;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_v3     <= VW'(s3_m1) - VW'(s3_m2);
      s4_v4     <= VW'(s3_m1) - VW'(s3_m3);
      s4_absdet <= s3_det[VW-1] ? VW'(-s3_det) : VW'(s3_det);
      s4_o1     <= s3_o1;
      s4_o2     <= s3_o2;
      s4_box    <= s3_box;
    end
  end

  // stage 5: flags
  turn_t o3, o4;
  logic  par, top;

  assign o3  = val_turn(s4_v3);
  assign o4  = val_turn(s4_v4);
  assign par = s4_absdet <= VW'(parallel_tolerance);
  assign top = ((s4_o1 != s4_o2) && (o3 != o4)) ||
               ((s4_o1 == TURN_COL) && s4_box[0]) ||
               ((s4_o2 == TURN_COL) && s4_box[1]) ||
               ((o3 == TURN_COL) && s4_box[2]) ||
               ((o4 == TURN_COL) && s4_box[3]);

  always_ff @(posedge clk) begin
    if (rdy5) begin
      out_item.parallel <= par;
      out_item.on_top   <= top;
      out_item.stacked  <= par && top;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parallel_tolerance <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (cfg_we) begin
        parallel_tolerance <= cfg_data;
      end
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  assign out_valid = v5;

endmodule
